@@ rtl/core/pairwise_share_handshake_table_top_assert.svh @@
// assertion macros for the pairwise share handshake table
`ifndef PAIRWISE_SHARE_HANDSHAKE_TABLE_TOP_ASSERT_SVH
`define PAIRWISE_SHARE_HANDSHAKE_TABLE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define PSHTBL_ASSERT_IMP(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("implication check failed");
`define PSHTBL_ASSERT_NEXT(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("next-cycle check failed");
`define PSHTBL_ASSERT_NEVER(lbl, clk, rst, a) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(a)) \
      else $error("forbidden condition seen");
`else
`define PSHTBL_ASSERT_IMP(lbl, clk, rst, a, b)
`define PSHTBL_ASSERT_NEXT(lbl, clk, rst, a, b)
`define PSHTBL_ASSERT_NEVER(lbl, clk, rst, a)
`endif
`endif

@@ rtl/core/pshtbl_pkg.sv @@
// shared types and constants of the pairwise share handshake table
package pshtbl_pkg;

   localparam int NUM_PROCESSES_DEF = 64;
   localparam int PROC_W = 6;
   localparam int VA_W = 32;

   localparam logic OP_OFFER = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef enum logic [1:0] {
      ST_PENDING = 2'd0,
      ST_READY   = 2'd1,
      ST_DEAD    = 2'd2
   } pshtbl_state_type;

   typedef struct packed {
      logic              operation;
      logic [PROC_W-1:0] source;
      logic [PROC_W-1:0] dest;
      logic [VA_W-1:0]   offer_va;
   } pshtbl_req_type;

   typedef struct packed {
      pshtbl_state_type status;
      logic             map_valid;
      logic [VA_W-1:0]  map_offer_va;
      logic [VA_W-1:0]  map_dest_va;
   } pshtbl_rsp_type;

   typedef struct packed {
      pshtbl_state_type state;
      logic             seen;
   } pshtbl_entry_type;

   typedef struct packed {
      logic st_we;
      logic addr_we;
   } pshtbl_wr_type;

   typedef struct packed {
      pshtbl_entry_type sd_entry;
      pshtbl_entry_type ds_entry;
      logic [VA_W-1:0]  ds_va;
   } pshtbl_rd_type;

endpackage

@@ rtl/core/pshtbl_store.sv @@
// pair table memories with the post-reset clearing sweep
module pshtbl_store #(
   parameter int  NUM_PROCESSES = pshtbl_pkg::NUM_PROCESSES_DEF,
   localparam int DEPTH = NUM_PROCESSES * NUM_PROCESSES,
   localparam int IDX_W = $clog2(DEPTH)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        rd_en,
   input  logic [IDX_W-1:0]            rd_sd_idx,
   input  logic [IDX_W-1:0]            rd_ds_idx,
   output pshtbl_pkg::pshtbl_rd_type   rd_data,
   input  pshtbl_pkg::pshtbl_wr_type   wr_ctl,
   input  logic [IDX_W-1:0]            wr_idx,
   input  pshtbl_pkg::pshtbl_entry_type wr_entry,
   input  logic [pshtbl_pkg::VA_W-1:0] wr_va,
   output logic                        clr_busy
);
   import pshtbl_pkg::*;

   pshtbl_entry_type st_mem [DEPTH];
   logic [VA_W-1:0]  va_mem [DEPTH];

   pshtbl_entry_type sd_q_ff;
   pshtbl_entry_type ds_q_ff;
   logic [VA_W-1:0]  va_q_ff;
   logic             clr_busy_ff;
   logic [IDX_W-1:0] clr_cnt_ff;

   // sweep every entry to dead/seen after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_cnt_ff  <= '0;
      end else if (clr_busy_ff) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == IDX_W'(DEPTH - 1)) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         st_mem[clr_cnt_ff] <= '{state: ST_DEAD, seen: 1'b1};
      end else if (wr_ctl.st_we) begin
         st_mem[wr_idx] <= wr_entry;
      end
      if (wr_ctl.addr_we) begin
         va_mem[wr_idx] <= wr_va;
      end
      if (rd_en) begin
         sd_q_ff <= st_mem[rd_sd_idx];
         ds_q_ff <= st_mem[rd_ds_idx];
         va_q_ff <= va_mem[rd_ds_idx];
      end
   end

   assign rd_data  = '{sd_entry: sd_q_ff, ds_entry: ds_q_ff, ds_va: va_q_ff};
   assign clr_busy = clr_busy_ff;

endmodule

@@ rtl/core/pshtbl_ctrl.sv @@
// request sequencer: read both pair entries, decide, write back, register the response
module pshtbl_ctrl #(
   parameter int  NUM_PROCESSES = pshtbl_pkg::NUM_PROCESSES_DEF,
   localparam int IDX_W = $clog2(NUM_PROCESSES * NUM_PROCESSES)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  pshtbl_pkg::pshtbl_req_type   req_word,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output pshtbl_pkg::pshtbl_rsp_type   rsp_word,
   input  logic                         clr_busy,
   output logic                         rd_en,
   output logic [IDX_W-1:0]             rd_sd_idx,
   output logic [IDX_W-1:0]             rd_ds_idx,
   input  pshtbl_pkg::pshtbl_rd_type    rd_data,
   output pshtbl_pkg::pshtbl_wr_type    wr_ctl,
   output logic [IDX_W-1:0]             wr_idx,
   output pshtbl_pkg::pshtbl_entry_type wr_entry,
   output logic [pshtbl_pkg::VA_W-1:0]  wr_va
);
   import pshtbl_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EVAL,
      S_WR2
   } fsm_type;

   localparam int NUM_W = $clog2(NUM_PROCESSES + 1);
   localparam int CMP_W = (NUM_W > PROC_W) ? NUM_W : PROC_W;

   fsm_type          state_ff, state_in;
   logic             rsp_valid_ff, rsp_valid_in;
   pshtbl_rsp_type   rsp_word_ff, rsp_word_in;
   logic             op_ff;
   logic [VA_W-1:0]  va_ff;
   logic [IDX_W-1:0] sd_idx_ff;
   logic [IDX_W-1:0] ds_idx_ff;
   logic             in_range_ff;

   logic             accept;
   logic             in_range;
   logic             out_free;
   logic             sd_pend;
   logic             ds_pend;
   pshtbl_state_type sd_status;

   assign req_ready = (state_ff == S_IDLE) && !clr_busy;
   assign accept    = req_valid && req_ready;
   assign in_range  = (CMP_W'(req_word.source) < CMP_W'(NUM_PROCESSES)) &&
                      (CMP_W'(req_word.dest) < CMP_W'(NUM_PROCESSES));

   // table read issued at the accepting edge
   assign rd_en     = accept && in_range;
   assign rd_sd_idx = IDX_W'(IDX_W'(req_word.source) * IDX_W'(NUM_PROCESSES) +
                             IDX_W'(req_word.dest));
   assign rd_ds_idx = IDX_W'(IDX_W'(req_word.dest) * IDX_W'(NUM_PROCESSES) +
                             IDX_W'(req_word.source));

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign sd_pend   = (rd_data.sd_entry.state == ST_PENDING);
   assign ds_pend   = (rd_data.ds_entry.state == ST_PENDING);
   assign sd_status = (rd_data.sd_entry.state == ST_PENDING ||
                       rd_data.sd_entry.state == ST_READY) ?
                      rd_data.sd_entry.state : ST_DEAD;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      wr_ctl       = '0;
      wr_idx       = sd_idx_ff;
      wr_entry     = '{state: ST_DEAD, seen: 1'b1};
      wr_va        = va_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = '{status: ST_DEAD, map_valid: 1'b0,
                                map_offer_va: '0, map_dest_va: '0};
               state_in     = S_IDLE;
               if (in_range_ff) begin
                  if (op_ff == OP_OFFER) begin
                     if (sd_pend) begin
                        rsp_word_in.status = ST_PENDING;
                     end else if (ds_pend) begin
                        // partner already offered: complete both directions
                        wr_ctl.st_we             = 1'b1;
                        wr_entry                 = '{state: ST_READY, seen: 1'b1};
                        rsp_word_in.status       = ST_READY;
                        rsp_word_in.map_valid    = 1'b1;
                        rsp_word_in.map_offer_va = va_ff;
                        rsp_word_in.map_dest_va  = rd_data.ds_va;
                        state_in                 = S_WR2;
                     end else begin
                        wr_ctl.st_we       = 1'b1;
                        wr_ctl.addr_we     = 1'b1;
                        wr_entry           = '{state: ST_PENDING, seen: 1'b1};
                        rsp_word_in.status = ST_PENDING;
                     end
                  end else begin
                     if (!rd_data.sd_entry.seen) begin
                        wr_ctl.st_we       = 1'b1;
                        wr_entry           = '{state: rd_data.sd_entry.state, seen: 1'b1};
                        rsp_word_in.status = sd_status;
                     end else if (ds_pend) begin
                        rsp_word_in.status = ST_PENDING;
                     end else begin
                        rsp_word_in.status = sd_status;
                     end
                  end
               end
            end
         end
         S_WR2: begin
            wr_ctl.st_we = 1'b1;
            wr_idx       = ds_idx_ff;
            wr_entry     = '{state: ST_READY, seen: 1'b0};
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
      if (accept) begin
         op_ff       <= req_word.operation;
         va_ff       <= req_word.offer_va;
         sd_idx_ff   <= rd_sd_idx;
         ds_idx_ff   <= rd_ds_idx;
         in_range_ff <= in_range;
      end
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

@@ rtl/core/pairwise_share_handshake_table_top.sv @@
// top level of the pairwise share handshake table
//
// request channel (req_valid/req_ready/req_word) takes offer or query words
// for an ordered process pair; response channel (rsp_valid/rsp_ready/rsp_word)
// returns exactly one word per request, in request order
// an offer parks the source address as pending (a repeat offer on a pending
// pair changes nothing), or completes the handshake when the partner is
// already pending, carrying both addresses out with map_valid set; a query
// reports the pair state and maintains seen
// flow: the pair entries (source,dest) and (dest,source) are read from a
// synchronous memory at the accepting edge, then decided and written back
// once the output register is free, with a further write step when an offer
// completes (the second entry goes through the single write port)
// one item is in flight at a time, which keeps reads behind all writes
// the response sits in an output register; a new request is accepted while
// it waits, and that request holds in its decide step until the register
// frees up, so a stalled receiver backs up onto the request channel
// reset: a sweep writes every pair to dead with seen set, one entry per cycle,
// holding req_ready low while it runs; stored addresses are not cleared
`include "pairwise_share_handshake_table_top_assert.svh"

module pairwise_share_handshake_table_top #(
   parameter int NUM_PROCESSES = pshtbl_pkg::NUM_PROCESSES_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  pshtbl_pkg::pshtbl_req_type req_word,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output pshtbl_pkg::pshtbl_rsp_type rsp_word
);
   import pshtbl_pkg::*;

   localparam int IDX_W = $clog2(NUM_PROCESSES * NUM_PROCESSES);

   // read and write ports between the sequencer and the table memories
   logic             rd_en;
   logic [IDX_W-1:0] rd_sd_idx;
   logic [IDX_W-1:0] rd_ds_idx;
   pshtbl_rd_type    rd_data;
   pshtbl_wr_type    wr_ctl;
   logic [IDX_W-1:0] wr_idx;
   pshtbl_entry_type wr_entry;
   logic [VA_W-1:0]  wr_va;
   logic             clr_busy;

   // terms for the checks at the end
   logic             tbl_write;
   logic             rsp_map;
   logic             map_addr_zero;

   // sequencer: handshakes, pair decision and response register
   pshtbl_ctrl #(
      .NUM_PROCESSES(NUM_PROCESSES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .clr_busy  (clr_busy),
      .rd_en     (rd_en),
      .rd_sd_idx (rd_sd_idx),
      .rd_ds_idx (rd_ds_idx),
      .rd_data   (rd_data),
      .wr_ctl    (wr_ctl),
      .wr_idx    (wr_idx),
      .wr_entry  (wr_entry),
      .wr_va     (wr_va)
   );

   // pair state/seen memory and address memory, plus the clearing sweep
   pshtbl_store #(
      .NUM_PROCESSES(NUM_PROCESSES)
   ) u_store (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (rd_en),
      .rd_sd_idx (rd_sd_idx),
      .rd_ds_idx (rd_ds_idx),
      .rd_data   (rd_data),
      .wr_ctl    (wr_ctl),
      .wr_idx    (wr_idx),
      .wr_entry  (wr_entry),
      .wr_va     (wr_va),
      .clr_busy  (clr_busy)
   );

   assign tbl_write     = wr_ctl.st_we || wr_ctl.addr_we;
   assign rsp_map       = rsp_valid && rsp_word.map_valid;
   assign map_addr_zero = (rsp_word.map_offer_va == '0) && (rsp_word.map_dest_va == '0);

   // no table write may collide with the clearing sweep
   `PSHTBL_ASSERT_NEVER(a_no_write_while_clearing, clock, reset, tbl_write && clr_busy)
   // one item in flight: an accept closes the request channel for the next cycle
   `PSHTBL_ASSERT_NEXT(a_single_item, clock, reset, req_valid && req_ready, !req_ready)
   // a mapping request only comes with a completed handshake
   `PSHTBL_ASSERT_IMP(a_map_is_ready, clock, reset, rsp_map, rsp_word.status == ST_READY)
   // map addresses are zero whenever no mapping is requested
   `PSHTBL_ASSERT_IMP(a_map_zero, clock, reset, rsp_valid && !rsp_word.map_valid, map_addr_zero)

endmodule

@@ tb/sv/pairwise_share_handshake_table_top_tb.sv @@
// self-checking testbench for the pairwise share handshake table top level
module pairwise_share_handshake_table_top_tb;
   import pshtbl_pkg::*;

   localparam int NPROC        = NUM_PROCESSES_DEF;
   localparam int RANDOM_ITEMS = 1200;
   localparam int DRAIN_CYCLES = 12;
   // budget covers the reset sweep plus ~1250 words, many times over
   localparam int CYCLE_LIMIT  = 400000;

   // one directed step: request word, whether the response is typed in, and that response
   typedef struct packed {
      pshtbl_req_type req;
      logic           typed;
      pshtbl_rsp_type rsp;
   } step_row_type;

   localparam pshtbl_rsp_type RSP_DEAD    = '{ST_DEAD, 1'b0, 32'h0, 32'h0};
   localparam pshtbl_rsp_type RSP_PENDING = '{ST_PENDING, 1'b0, 32'h0, 32'h0};
   localparam pshtbl_rsp_type RSP_NONE    = '0;

   localparam int N_DIRECTED = 22;
   localparam step_row_type DIRECTED [N_DIRECTED] = '{
      // fresh table: every pair dead with seen set
      '{'{OP_QUERY, 6'd0,  6'd0,  32'h0000_0000}, 1'b1, RSP_DEAD},
      '{'{OP_QUERY, 6'd63, 6'd63, 32'hFFFF_FFFF}, 1'b1, RSP_DEAD},
      '{'{OP_QUERY, 6'd0,  6'd63, 32'h0000_0000}, 1'b1, RSP_DEAD},
      // first offer parks the address, a repeat offer changes nothing
      '{'{OP_OFFER, 6'd0,  6'd63, 32'hFFFF_FFFF}, 1'b1, RSP_PENDING},
      '{'{OP_OFFER, 6'd0,  6'd63, 32'h0000_0000}, 1'b1, RSP_PENDING},
      '{'{OP_QUERY, 6'd0,  6'd63, 32'h0000_0000}, 1'b0, RSP_NONE},
      '{'{OP_QUERY, 6'd63, 6'd0,  32'h0000_0000}, 1'b0, RSP_NONE},
      // partner offer completes the handshake with the parked address
      '{'{OP_OFFER, 6'd63, 6'd0,  32'h0000_0000}, 1'b1,
        '{ST_READY, 1'b1, 32'h0000_0000, 32'hFFFF_FFFF}},
      '{'{OP_QUERY, 6'd63, 6'd0,  32'h0000_0000}, 1'b0, RSP_NONE},
      '{'{OP_QUERY, 6'd0,  6'd63, 32'h0000_0000}, 1'b0, RSP_NONE},
      '{'{OP_QUERY, 6'd0,  6'd63, 32'h0000_0000}, 1'b0, RSP_NONE},
      // offer on a ready pair goes pending again, then the partner completes it
      '{'{OP_OFFER, 6'd63, 6'd0,  32'h5A5A_5A5A}, 1'b0, RSP_NONE},
      '{'{OP_OFFER, 6'd0,  6'd63, 32'hA5A5_A5A5}, 1'b1,
        '{ST_READY, 1'b1, 32'hA5A5_A5A5, 32'h5A5A_5A5A}},
      // source equal to dest: one record, an offer only goes pending
      '{'{OP_OFFER, 6'd42, 6'd42, 32'h1234_5678}, 1'b1, RSP_PENDING},
      '{'{OP_OFFER, 6'd42, 6'd42, 32'h8765_4321}, 1'b1, RSP_PENDING},
      '{'{OP_QUERY, 6'd42, 6'd42, 32'h0000_0000}, 1'b0, RSP_NONE},
      // alternating bit patterns on the process numbers
      '{'{OP_OFFER, 6'd21, 6'd42, 32'h0000_0001}, 1'b0, RSP_NONE},
      '{'{OP_OFFER, 6'd42, 6'd21, 32'h8000_0000}, 1'b1,
        '{ST_READY, 1'b1, 32'h8000_0000, 32'h0000_0001}},
      '{'{OP_QUERY, 6'd21, 6'd42, 32'h0000_0000}, 1'b0, RSP_NONE},
      '{'{OP_QUERY, 6'd42, 6'd21, 32'h0000_0000}, 1'b0, RSP_NONE},
      '{'{OP_OFFER, 6'd21, 6'd42, 32'h0000_0000}, 1'b0, RSP_NONE},
      '{'{OP_QUERY, 6'd42, 6'd21, 32'h0000_0000}, 1'b0, RSP_NONE}
   };

   logic           clock;
   logic           reset     = 1'b1;
   logic           req_valid = 1'b0;
   logic           req_ready;
   pshtbl_req_type req_word  = '0;
   logic           rsp_valid;
   logic           rsp_ready = 1'b0;
   pshtbl_rsp_type rsp_word;

   // predictor copy of the pair table
   pshtbl_state_type pair_st   [NPROC*NPROC];
   logic             pair_seen [NPROC*NPROC];
   logic [VA_W-1:0]  pair_va   [NPROC*NPROC];

   pshtbl_rsp_type rsp_owed [$];   // responses owed, oldest first
   int             n_taken   = 0;  // request words accepted
   int             items_sent = 0;
   int             burst_left = 0;
   int             n_fail    = 0;
   logic           cur_typed = 1'b0; // typed-in response for the word on the bus
   pshtbl_rsp_type cur_rsp   = '0;

   pairwise_share_handshake_table_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // applies one word to the predicted table and returns the response it earns
   function automatic pshtbl_rsp_type handshake_outcome(input pshtbl_req_type w);
      pshtbl_rsp_type   r;
      int               sd;
      int               ds;
      pshtbl_state_type sd_st;
      pshtbl_state_type ds_st;
      r = RSP_DEAD;
      // process out of range: no change, dead with map fields zero
      if (w.source >= NPROC || w.dest >= NPROC) return r;
      sd = w.source * NPROC + w.dest;
      ds = w.dest * NPROC + w.source;
      sd_st = pair_st[sd];
      ds_st = pair_st[ds];
      if (w.operation == OP_OFFER) begin
         r.status = ST_PENDING;
         // already pending: nothing moves
         if (sd_st != ST_PENDING) begin
            if (ds_st == ST_PENDING) begin
               // partner waits: both sides ready, partner must see it once
               pair_st[sd]    = ST_READY;
               pair_seen[sd]  = 1'b1;
               pair_st[ds]    = ST_READY;
               pair_seen[ds]  = 1'b0;
               r.status       = ST_READY;
               r.map_valid    = 1'b1;
               r.map_offer_va = w.offer_va;
               r.map_dest_va  = pair_va[ds];
            end else begin
               pair_st[sd]   = ST_PENDING;
               pair_seen[sd] = 1'b1;
               pair_va[sd]   = w.offer_va;
            end
         end
      end else begin
         if (!pair_seen[sd]) begin
            pair_seen[sd] = 1'b1;
            r.status      = sd_st;
         end else if (ds_st == ST_PENDING) begin
            r.status = ST_PENDING;
         end else begin
            r.status = sd_st;
         end
      end
      return r;
   endfunction

   function automatic pshtbl_req_type req_of(input logic op, input logic [PROC_W-1:0] s,
                                             input logic [PROC_W-1:0] d,
                                             input logic [VA_W-1:0] va);
      pshtbl_req_type w;
      w.operation = op;
      w.source    = s;
      w.dest      = d;
      w.offer_va  = va;
      return w;
   endfunction

   // mostly a handful of processes so pairs meet again, sometimes any process
   function automatic logic [PROC_W-1:0] pick_proc();
      int v;
      if ($urandom_range(0, 9) < 7) begin
         v = $urandom_range(0, 7);
         return (v < 4) ? PROC_W'(v) : PROC_W'(56 + v);
      end
      return PROC_W'($urandom_range(0, NPROC - 1));
   endfunction

   function automatic logic [VA_W-1:0] pick_va();
      case ($urandom_range(0, 9))
         0: begin
            return '0;
         end
         1: begin
            return '1;
         end
         default: begin
            return $urandom;
         end
      endcase
   endfunction

   task automatic check_field(input string name, input logic [VA_W-1:0] want,
                              input logic [VA_W-1:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0h, actual %0h", name, want, got);
         n_fail++;
      end
   endtask

   // puts one word on the request channel at a falling edge and waits for the handshake;
   // returns at the falling edge after acceptance with valid still high
   task automatic send_word(input pshtbl_req_type w, input logic typed,
                            input pshtbl_rsp_type trsp);
      int   taken;
      logic drain;
      // once in a while hold off until every owed response is back
      drain = (items_sent % 400 == 399);
      if (burst_left == 0 || drain) begin
         req_valid <= 1'b0;
         if (drain) begin
            while (rsp_owed.size() != 0) @(negedge clock);
         end
         repeat ($urandom_range(1, 6)) @(negedge clock);
         // mix of short bursts and long gapless stretches
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      cur_typed = typed;
      cur_rsp   = trsp;
      taken     = n_taken;
      do @(negedge clock); while (n_taken == taken);
      burst_left--;
      items_sent++;
   endtask

   // scoreboard: predict on request acceptance, compare on response acceptance
   always @(posedge clock) begin
      pshtbl_rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            want = handshake_outcome(req_word);
            rsp_owed.push_back(cur_typed ? cur_rsp : want);
            n_taken++;
         end
         if (rsp_valid && rsp_ready) begin
            if (rsp_owed.size() == 0) begin
               $error("response word with nothing owed");
               n_fail++;
            end else begin
               want = rsp_owed.pop_front();
               check_field("status", VA_W'(want.status), VA_W'(rsp_word.status));
               check_field("map_valid", VA_W'(want.map_valid), VA_W'(rsp_word.map_valid));
               check_field("map_offer_va", want.map_offer_va, rsp_word.map_offer_va);
               check_field("map_dest_va", want.map_dest_va, rsp_word.map_dest_va);
            end
         end
      end
   end

   // receiver: ready stretches, coin-flip stretches and short full stalls
   initial begin
      int mode;
      int len;
      forever begin
         mode = $urandom_range(0, 2);
         len  = (mode == 2) ? $urandom_range(1, 8) : $urandom_range(1, 40);
         repeat (len) begin
            @(negedge clock);
            case (mode)
               0: begin
                  rsp_ready <= 1'b1;
               end
               1: begin
                  rsp_ready <= $urandom_range(0, 1);
               end
               default: begin
                  rsp_ready <= 1'b0;
               end
            endcase
         end
      end
   end

   // watchdog
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      logic [PROC_W-1:0] a;
      logic [PROC_W-1:0] b;
      int                kind;
      // reset state of the table: dead with seen set, addresses unwritten
      for (int i = 0; i < NPROC * NPROC; i++) begin
         pair_st[i]   = ST_DEAD;
         pair_seen[i] = 1'b1;
         pair_va[i]   = '0;
      end
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      // the clearing sweep keeps req_ready low; send_word just waits it out

      for (int i = 0; i < N_DIRECTED; i++) begin
         send_word(DIRECTED[i].req, DIRECTED[i].typed, DIRECTED[i].rsp);
      end

      while (items_sent < N_DIRECTED + RANDOM_ITEMS) begin
         a    = pick_proc();
         b    = pick_proc();
         kind = $urandom_range(0, 9);
         if (kind < 9) begin
            // handshake between a and b, broken (repeat offer) in a few cases
            send_word(req_of(OP_OFFER, a, b, pick_va()), 1'b0, RSP_NONE);
            if ($urandom_range(0, 1)) begin
               send_word(req_of(OP_QUERY, b, a, pick_va()), 1'b0, RSP_NONE);
            end
            if (kind < 7) begin
               send_word(req_of(OP_OFFER, b, a, pick_va()), 1'b0, RSP_NONE);
            end else begin
               send_word(req_of(OP_OFFER, a, b, pick_va()), 1'b0, RSP_NONE);
            end
            repeat ($urandom_range(1, 4)) begin
               if ($urandom_range(0, 1)) begin
                  send_word(req_of(OP_QUERY, a, b, pick_va()), 1'b0, RSP_NONE);
               end else begin
                  send_word(req_of(OP_QUERY, b, a, pick_va()), 1'b0, RSP_NONE);
               end
            end
         end else begin
            // noise: any operation on any pair
            repeat ($urandom_range(1, 4)) begin
               send_word(req_of(1'($urandom_range(0, 1)),
                                PROC_W'($urandom_range(0, NPROC - 1)),
                                PROC_W'($urandom_range(0, NPROC - 1)), $urandom),
                         1'b0, RSP_NONE);
            end
         end
      end

      req_valid <= 1'b0;
      while (rsp_owed.size() != 0) @(negedge clock);
      // keep clocking to catch any stray response word
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (n_fail == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
